[rtl/core/pli_pkg.sv]
`default_nettype none

package pli_pkg;

   // Table geometry.
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Fixed field widths.
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int STEP_W     = $clog2(DATA_W);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     operation;
      logic [5:0]               point_index;
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     in_range;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } bp_entry_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

[rtl/core/piecewise_linear_interpolator_top.sv]
// Write item: accepted while idle and stored at the accepting edge; no result item.
// Query item: the table entries are read in turn, pipelined, until a segment holds the query
// or the last point in use is reached; with fewer than two points in use there is no scan.
// On a match the result passes a multiply state, a divider load state and the divider; a
// zero-width match skips the divider. A result that is not taken stalls the next query.
`default_nettype none

module piecewise_linear_interpolator_top
   import pli_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output rsp_type    rsp_data,
   input  wire        csr_we,
   input  wire [6:0]  csr_data
);

   // Sequencer state. Reset (synchronous, active high) clears control state and
   // point_count; the breakpoint table is not cleared.
   state_type state_ff, state_in;

   // Configuration register.
   logic [6:0] count_ff, count_in;

   // Scan control: read pointer, and the index of the entry the RAM returns.
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] data_idx_ff, data_idx_in;
   logic             dvalid_ff, dvalid_in;

   // Query and segment datapath.
   logic signed [DATA_W-1:0] query_ff, query_in;
   bp_entry_type             prev_ff, prev_in;
   logic signed [DATA_W-1:0] y0_ff, y0_in;
   logic [DATA_W-1:0]        mag_ff, mag_in;
   logic [DATA_W-1:0]        dq_ff, dq_in;
   logic [DATA_W-1:0]        dx_ff, dx_in;
   logic                     neg_ff, neg_in;
   logic                     hit_ff, hit_in;
   logic                     zero_ff, zero_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Handshakes and unit controls.
   logic        req_acc;
   logic        is_query;
   logic        slot_free;
   logic        ram_we;
   logic        ram_re;
   bp_entry_type ram_wdata;
   bp_entry_type ram_rdata;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Segment test on the entry that the RAM returns this cycle.
   logic            seg_match;
   logic            last_entry;
   logic [DATA_W:0] dx_full;
   logic [DATA_W:0] dq_full;
   logic [DATA_W:0] dy_full;
   logic [DATA_W:0] dy_abs;
   logic [DATA_W-1:0] n_limit;

   // Final sum and saturation.
   logic signed [DATA_W+1:0] sum;
   logic signed [DATA_W-1:0] sat_value;

   localparam logic signed [DATA_W+1:0] SumMax = {3'b000, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W+1:0] SumMin = {3'b111, {(DATA_W-1){1'b0}}};

   assign req_acc   = req_valid && req_ready;
   assign is_query  = req_data.operation == OP_QUERY;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Configured point count, widened; a count above the table size is taken as the table size below.
   assign n_limit = DATA_W'(count_ff);

   assign seg_match  = (query_ff >= prev_ff.x) && (query_ff <= ram_rdata.x);
   assign last_entry = data_idx_ff == (n_ff - CNT_W'(1));
   assign dx_full    = {ram_rdata.x[DATA_W-1], ram_rdata.x} - {prev_ff.x[DATA_W-1], prev_ff.x};
   assign dq_full    = {query_ff[DATA_W-1], query_ff} - {prev_ff.x[DATA_W-1], prev_ff.x};
   assign dy_full    = {ram_rdata.y[DATA_W-1], ram_rdata.y} - {prev_ff.y[DATA_W-1], prev_ff.y};
   assign dy_abs     = dy_full[DATA_W] ? (~dy_full + (DATA_W+1)'(1)) : dy_full;

   // The quotient never exceeds the magnitude of the ordinate step, so it
   // fits in DATA_W bits and the sum stays within DATA_W + 2 bits.
   always_comb begin
      if (neg_ff) begin
         sum = {{2{y0_ff[DATA_W-1]}}, y0_ff} - {2'b00, div_rsp.quotient};
      end else begin
         sum = {{2{y0_ff[DATA_W-1]}}, y0_ff} + {2'b00, div_rsp.quotient};
      end
      if (sum > SumMax) begin
         sat_value = SumMax[DATA_W-1:0];
      end else if (sum < SumMin) begin
         sat_value = SumMin[DATA_W-1:0];
      end else begin
         sat_value = sum[DATA_W-1:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_query) begin
               state_in = (n_in < CNT_W'(2)) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dvalid_ff && (data_idx_ff != '0)) begin
               if (seg_match) begin
                  state_in = (dx_full == '0) ? ST_DONE : ST_MUL;
               end else if (last_entry) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer. The table is written only while idle and read
   // only while scanning, so reads and writes of one entry never overlap.
   always_comb begin
      req_ready        = 1'b0;
      ram_we           = 1'b0;
      ram_re           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = dx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ram_we    = req_valid && !is_query && (32'(req_data.point_index) < MAX_POINTS);
         end
         ST_SCAN: ram_re = rd_idx_ff < n_ff;
         ST_LOAD: div_req.start = 1'b1;
         ST_MUL, ST_DIV, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign ram_wdata = '{x: req_data.point_x, y: req_data.point_y};

   // Datapath next values.
   always_comb begin
      count_in     = csr_we ? csr_data : count_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      data_idx_in  = rd_idx_ff;
      dvalid_in    = ram_re;
      query_in     = query_ff;
      prev_in      = prev_ff;
      y0_in        = y0_ff;
      mag_in       = mag_ff;
      dq_in        = dq_ff;
      dx_in        = dx_ff;
      neg_in       = neg_ff;
      hit_in       = hit_ff;
      zero_in      = zero_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (n_limit > MAX_POINTS) begin
         n_in = CNT_W'(MAX_POINTS);
      end else begin
         n_in = CNT_W'(count_ff);
      end
      if (!(state_ff == ST_IDLE && req_acc && is_query)) begin
         n_in = n_ff;
      end

      if (state_ff == ST_IDLE && req_acc && is_query) begin
         query_in  = req_data.query_x;
         rd_idx_in = '0;
         hit_in    = 1'b0;
         zero_in   = 1'b0;
      end

      if (ram_re) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end

      if (state_ff == ST_SCAN && dvalid_ff) begin
         if (data_idx_ff == '0) begin
            prev_in = ram_rdata;
         end else if (seg_match) begin
            hit_in  = 1'b1;
            zero_in = dx_full == '0;
            y0_in   = prev_ff.y;
            dx_in   = dx_full[DATA_W-1:0];
            dq_in   = dq_full[DATA_W-1:0];
            neg_in  = dy_full[DATA_W];
            mag_in  = dy_abs[DATA_W-1:0];
         end else begin
            prev_in = ram_rdata;
         end
      end

      if (state_ff == ST_MUL) begin
         prod_in = mag_ff * dq_ff;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.in_range = hit_ff;
         if (!hit_ff) begin
            rsp_data_in.value = '0;
         end else if (zero_ff) begin
            rsp_data_in.value = y0_ff;
         end else begin
            rsp_data_in.value = sat_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      rd_idx_ff   <= rd_idx_in;
      data_idx_ff <= data_idx_in;
      query_ff    <= query_in;
      prev_ff     <= prev_in;
      y0_ff       <= y0_in;
      mag_ff      <= mag_in;
      dq_ff       <= dq_in;
      dx_ff       <= dx_in;
      neg_ff      <= neg_in;
      hit_ff      <= hit_in;
      zero_ff     <= zero_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   pli_bp_ram u_bp_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(req_data.point_index)),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   pli_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A write item never starts a query.
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !is_query) |=> state_ff == ST_IDLE)
      else $error("write item left the idle state");

   // The divider only runs on a matched segment of nonzero width.
   a_div_on_real_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (hit_ff && !zero_ff))
      else $error("divider used without a valid segment");

   // A new result is loaded only on leaving the done state.
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared outside the done state");

   // An out-of-range result carries a zero value.
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.in_range) |-> rsp_data_ff.value == '0)
      else $error("out-of-range result with nonzero value");
`endif

endmodule

`default_nettype wire

[rtl/core/pli_bp_ram.sv]
`default_nettype none

module pli_bp_ram
   import pli_pkg::*;
(
   input  wire                 clock,
   input  wire                 wr_en,
   input  wire [IDX_W-1:0]     wr_addr,
   input  bp_entry_type        wr_data,
   input  wire                 rd_en,
   input  wire [IDX_W-1:0]     rd_addr,
   output bp_entry_type        rd_data
);

   // Breakpoint table; contents are undefined until written.
   bp_entry_type mem [MAX_POINTS];
   bp_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/pli_divider.sv]
`default_nettype none

module pli_divider
   import pli_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring division, one quotient bit per cycle. The caller guarantees
   // that the quotient fits in DATA_W bits, so the high half of the dividend
   // starts out below the divisor.
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] dvsr_ff, dvsr_in;

   logic [DATA_W:0]   trial;
   logic              fits;
   logic [DATA_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, lo_ff[DATA_W-1]};
      fits    = trial >= {1'b0, dvsr_ff};
      diff    = trial - {1'b0, dvsr_ff};
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      dvsr_in = dvsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = req.dividend[PROD_W-1:DATA_W];
         lo_in   = req.dividend[DATA_W-1:0];
         dvsr_in = req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         lo_in   = {lo_ff[DATA_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      dvsr_ff <= dvsr_in;
   end

   assign rsp = '{busy: busy_ff, done: done_ff, quotient: lo_ff};

endmodule

`default_nettype wire

[dv/piecewise_linear_interpolator_top_tb.sv]
`default_nettype none

module piecewise_linear_interpolator_top_tb;
   import pli_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int IDLE_PCT       = 29;
   localparam int RANDOM_ITEMS   = 1800;
   // Long enough for a full scan of the table and the divider.
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // Keeps a shadow of the breakpoint table and the point count, and holds the
   // interpolated values still owed by the block, oldest first.
   class interp_scoreboard;
      logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
      logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
      logic [6:0]               point_count;
      rsp_type                  owed_values [$];
      int errors;
      int writes;
      int queries;
      int hits;
      int count_settings;

      function new();
         point_count    = '0;
         errors         = 0;
         writes         = 0;
         queries        = 0;
         hits           = 0;
         count_settings = 0;
      endfunction

      function rsp_type interpolate(logic signed [DATA_W-1:0] q);
         rsp_type     res;
         int          n;
         longint      x0, x1, y0, y1, dy, r;
         logic [63:0] dx, dq, mag, quo;
         res.value    = '0;
         res.in_range = 1'b0;
         n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
         for (int i = 0; i + 1 < n; i++) begin
            x0 = bp_x[i];
            x1 = bp_x[i + 1];
            if (q >= x0 && q <= x1) begin
               y0 = bp_y[i];
               y1 = bp_y[i + 1];
               if (x1 == x0) begin
                  // A segment of zero width holds its left ordinate.
                  r = y0;
               end else begin
                  dy  = y1 - y0;
                  dx  = x1 - x0;
                  dq  = q - x0;
                  mag = (dy < 0) ? -dy : dy;
                  quo = (mag * dq) / dx;
                  r   = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
               end
               if (r > SAT_HI) r = SAT_HI;
               if (r < SAT_LO) r = SAT_LO;
               res.value    = r[DATA_W-1:0];
               res.in_range = 1'b1;
               break;
            end
         end
         return res;
      endfunction

      function void note_request(req_type item);
         rsp_type owed;
         if (item.operation == OP_WRITE) begin
            bp_x[item.point_index] = item.point_x;
            bp_y[item.point_index] = item.point_y;
            writes++;
         end else begin
            owed = interpolate(item.query_x);
            owed_values.push_back(owed);
            queries++;
            if (owed.in_range) hits++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type owed;
         if (owed_values.size() == 0) begin
            $display("%0t: result with no query outstanding, expected none, actual value %h in_range %b",
                     $time, got.value, got.in_range);
            errors++;
         end else begin
            owed = owed_values.pop_front();
            if (got.value !== owed.value) begin
               $display("%0t: value mismatch, expected %h, actual %h",
                        $time, owed.value, got.value);
               errors++;
            end
            if (got.in_range !== owed.in_range) begin
               $display("%0t: in_range mismatch, expected %b, actual %b",
                        $time, owed.in_range, got.in_range);
               errors++;
            end
         end
      endfunction
   endclass

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic [6:0] csr_data  = '0;

   // While quiet is set neither side idles.
   bit quiet       = 1'b0;
   int items_sent  = 0;
   int stall_count = 0;

   interp_scoreboard tables = new();

   piecewise_linear_interpolator_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_data  (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // The result side stalls at random except during the quiet stretch.
   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // Both channels are sampled at the rising edge. The watchdog counts edges
   // at which neither channel moves an item.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tables.note_request(req_data);
         if (rsp_valid && rsp_ready) tables.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_count = 0;
         end else begin
            stall_count++;
            if (stall_count >= WATCHDOG_LIMIT) begin
               $display("%0t: no item moved for %0d cycles, run abandoned",
                        $time, WATCHDOG_LIMIT);
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   // Presents one item, possibly after a random gap, and returns at the edge
   // that accepts it. Valid is only lowered when a gap actually follows.
   task automatic send_item(req_type item);
      int gap;
      gap = 0;
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tables.owed_values.size() != 0) @(negedge clock);
   endtask

   // The block is idle once every query has answered and a full query time
   // has gone by after the last write.
   task automatic drain_block();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_point_count(int n);
      drain_block();
      csr_we   <= 1'b1;
      csr_data <= n[6:0];
      @(negedge clock);
      csr_we <= 1'b0;
      tables.point_count = n[6:0];
      tables.count_settings++;
   endtask

   // Fields that an operation does not use carry random noise.
   function automatic req_type write_item(int idx, logic [31:0] x, logic [31:0] y);
      req_type item;
      item.operation   = OP_WRITE;
      item.point_index = idx[5:0];
      item.point_x     = x;
      item.point_y     = y;
      item.query_x     = $urandom;
      return item;
   endfunction

   function automatic req_type query_item(logic [31:0] q);
      req_type item;
      item.operation   = OP_QUERY;
      item.point_index = $urandom;
      item.point_x     = $urandom;
      item.point_y     = $urandom;
      item.query_x     = q;
      return item;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic longint pick_between(longint lo, longint hi);
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      return lo + longint'(rnd % (hi - lo + 1));
   endfunction

   task automatic run_directed();
      // A single segment spanning the whole range, falling from the largest
      // ordinate to the smallest, stresses the product and the divider.
      send_item(write_item(0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_item(write_item(1, 32'h7FFF_FFFF, 32'h8000_0000));
      // With fewer than two points in use there is no segment at all.
      send_item(query_item(32'h0000_0000));
      write_point_count(1);
      send_item(query_item(32'h0000_0000));
      write_point_count(2);
      send_item(query_item(32'h8000_0000));
      send_item(query_item(32'h7FFF_FFFF));
      send_item(query_item(32'h0000_0000));
      send_item(query_item(32'hFFFF_FFFF));
      send_item(query_item(32'h0000_0001));
      // A table that starts with a zero-width segment, then holds a falling
      // abscissa that makes one segment unreachable.
      send_item(write_item(0, 32'h0001_0000, 32'h0001_2345));
      send_item(write_item(1, 32'h0001_0000, 32'h0005_5555));
      send_item(write_item(2, 32'h0003_0000, 32'h7FFF_FFFF));
      send_item(write_item(3, 32'hFFFE_0000, 32'h8000_0000));
      send_item(write_item(4, 32'h0004_0000, 32'hFFFF_0000));
      send_item(write_item(5, 32'h7FFF_FFFF, 32'h0000_0000));
      send_item(write_item(63, 32'h5555_5555, 32'hAAAA_AAAA));
      write_point_count(6);
      send_item(query_item(32'h0001_0000));
      send_item(query_item(32'h0002_0000));
      send_item(query_item(32'hFFFF_8000));
      send_item(query_item(32'h8000_0000));
      send_item(query_item(32'h7FFF_FFFF));
      send_item(query_item(32'h0004_0000));
   endtask

   // Loads a fresh table covering every point in use, sets the point count
   // and then sends queries mixed with the odd stray write.
   task automatic run_table_phase(int n, int n_queries, bit force_pause);
      longint      xs [MAX_POINTS];
      int          n_eff, fill, rot, idx, sel;
      bit          sorted;
      longint      gap_max, room, xcur, lo, hi, qv;
      logic [63:0] rnd;
      n_eff  = (n > MAX_POINTS) ? MAX_POINTS : n;
      fill   = (n_eff < 2) ? 2 : n_eff;
      sorted = ($urandom_range(99) < 85);
      case ($urandom_range(3))
         0:       gap_max = 16;
         1:       gap_max = 65536;
         2:       gap_max = 64'd16777216;
         default: gap_max = 64'd4294967295 / fill;
      endcase
      room = 64'd4294967295 - gap_max * (fill - 1);
      xcur = (room <= 0) ? SAT_LO : pick_between(SAT_LO, SAT_LO + room);
      for (int i = 0; i < fill; i++) begin
         xs[i] = sorted ? xcur : longint'($signed($urandom));
         // Repeated abscissas give zero-width segments.
         if ($urandom_range(9) != 0) begin
            rnd  = {$urandom, $urandom};
            xcur = xcur + longint'(rnd % gap_max) + 1;
            if (xcur > SAT_HI) xcur = SAT_HI;
         end
      end
      rot = $urandom_range(fill - 1);
      for (int i = 0; i < fill; i++) begin
         idx = (i + rot) % fill;
         send_item(write_item(idx, xs[idx][31:0], pick_word()));
      end
      write_point_count(n);
      lo = xs[0];
      hi = xs[0];
      for (int i = 1; i < fill; i++) begin
         if (xs[i] < lo) lo = xs[i];
         if (xs[i] > hi) hi = xs[i];
      end
      for (int k = 0; k < n_queries; k++) begin
         if (force_pause && k == n_queries / 2) wait_for_results();
         else if ($urandom_range(99) < 4) wait_for_results();
         if ($urandom_range(99) < 8) begin
            // A stray write may land inside the table or above it.
            send_item(write_item($urandom_range(MAX_POINTS - 1), $urandom, pick_word()));
         end
         sel = $urandom_range(9);
         if (sel < 7) begin
            qv = pick_between(lo, hi);
         end else if (sel == 7) begin
            qv = xs[$urandom_range(fill - 1)] + $urandom_range(2) - 1;
            if (qv > SAT_HI) qv = SAT_HI;
            if (qv < SAT_LO) qv = SAT_LO;
         end else begin
            qv = $signed(pick_word());
         end
         send_item(query_item(qv[31:0]));
      end
   endtask

   initial begin
      int phase;
      int n;
      int target;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      target = items_sent + RANDOM_ITEMS;
      phase  = 0;
      while (items_sent < target) begin
         case (phase)
            0:       n = MAX_POINTS;
            1:       n = 127;
            2:       n = 2;
            default: begin
               case ($urandom_range(9))
                  0:       n = $urandom_range(1);
                  1, 2, 3,
                  4, 5, 6: n = $urandom_range(2, 12);
                  7:       n = $urandom_range(13, 40);
                  8:       n = $urandom_range(41, MAX_POINTS);
                  default: n = $urandom_range(MAX_POINTS + 1, 127);
               endcase
            end
         endcase
         // One phase runs with neither side idling.
         quiet = (phase == 3);
         run_table_phase(n, $urandom_range(15, 40), phase == 2);
         phase++;
      end
      quiet = 1'b0;

      drain_block();
      $display("Covered %0d breakpoint writes and %0d queries, %0d of them inside a segment,",
               tables.writes, tables.queries, tables.hits);
      $display("over %0d point-count settings from zero to the 7-bit maximum.",
               tables.count_settings);
      if (tables.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
